// ===== sv/itp_pkg.sv =====
// Shared types, constants and lookup functions for the infix to postfix converter.
`default_nettype none
package itp_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int Q_DEPTH     = 2;
  localparam int QP_W        = $clog2(Q_DEPTH);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_CARET = 8'h5E;

  localparam logic [2:0] CODE_OPEN  = 3'd0;
  localparam logic [2:0] CODE_PLUS  = 3'd1;
  localparam logic [2:0] CODE_MINUS = 3'd2;
  localparam logic [2:0] CODE_STAR  = 3'd3;
  localparam logic [2:0] CODE_SLASH = 3'd4;
  localparam logic [2:0] CODE_PCT   = 3'd5;
  localparam logic [2:0] CODE_CARET = 3'd6;
  localparam logic [2:0] CODE_NONE  = 3'd7;

  localparam logic [2:0] ACT_END    = 3'd0;
  localparam logic [2:0] ACT_DIGIT  = 3'd1;
  localparam logic [2:0] ACT_OPEN   = 3'd2;
  localparam logic [2:0] ACT_CLOSE  = 3'd3;
  localparam logic [2:0] ACT_BIN    = 3'd4;
  localparam logic [2:0] ACT_UNARY  = 3'd5;
  localparam logic [2:0] ACT_IGNORE = 3'd6;

  localparam logic [1:0] CLS_START = 2'd0;
  localparam logic [1:0] CLS_OPER  = 2'd1;
  localparam logic [1:0] CLS_OPEN  = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  typedef struct packed {
    logic [2:0] act;
    logic [2:0] code;
    logic [7:0] ch;
    logic       space_first;
  } rec_t;

  function automatic logic [2:0] oper_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      CH_PLUS:  r = CODE_PLUS;
      CH_MINUS: r = CODE_MINUS;
      CH_STAR:  r = CODE_STAR;
      CH_SLASH: r = CODE_SLASH;
      CH_PCT:   r = CODE_PCT;
      CH_CARET: r = CODE_CARET;
      default:  r = CODE_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input logic [2:0] code);
    logic [7:0] r;
    case (code)
      CODE_OPEN:  r = CH_OPEN;
      CODE_PLUS:  r = CH_PLUS;
      CODE_MINUS: r = CH_MINUS;
      CODE_STAR:  r = CH_STAR;
      CODE_SLASH: r = CH_SLASH;
      CODE_PCT:   r = CH_PCT;
      CODE_CARET: r = CH_CARET;
      default:    r = CH_NUL;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] code_prec(input logic [2:0] code);
    logic [1:0] r;
    case (code)
      CODE_PLUS, CODE_MINUS:          r = 2'd1;
      CODE_STAR, CODE_SLASH, CODE_PCT: r = 2'd2;
      CODE_CARET:                     r = 2'd3;
      default:                        r = 2'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/infix_to_postfix_converter.sv =====
// Top level of the infix to postfix converter: front end, record queue, stack engine.
//
//   channel | direction | tdata    | tuser    | tlast
//   s_*     | in        | ch       | kind     | -
//   m_*     | out       | out_char | overflow | last
//
// Each input transaction is dispatched from the queue head in the stack engine, then
// emits its result characters one by one; a digit emits itself, an open bracket or an
// ignored character nothing but a leading space. A closing bracket or a binary operator
// ends its pop loop in a state that emits nothing. One stack engine state machine runs both.
// Reset is synchronous; it empties the queue, the stack and the output register.
// A stalled output holds the engine; the two-entry queue takes input until full.
`default_nettype none
module infix_to_postfix_converter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // ch
  input  wire logic       s_tuser,   // kind
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // out_char
  output logic            m_tlast,   // last
  output logic            m_tuser    // overflow
);
  import itp_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  rec_t q_in;
  rec_t q_head;

  itp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_rec    (q_in)
  );

  itp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_rec   (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  itp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
`default_nettype wire

// ===== sv/itp_front.sv =====
// Front end: accepts input characters and classifies them into queue records.
`default_nettype none
module itp_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // ch
  input  wire logic        s_tuser,   // kind
  input  wire logic        q_full,
  output logic             q_push,
  output itp_pkg::rec_t    q_rec
);
  import itp_pkg::*;

  logic       in_number;
  logic [1:0] prev_class;
  logic       in_number_next;
  logic [1:0] prev_class_next;
  logic       is_digit;
  logic [2:0] code;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;
  assign is_digit = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
  assign code     = oper_code(s_tdata);

  always_comb begin
    q_rec.ch          = s_tdata;
    q_rec.code        = code;
    q_rec.space_first = in_number && (s_tuser || !is_digit);
    q_rec.act         = ACT_IGNORE;
    in_number_next    = 1'b0;
    prev_class_next   = CLS_OTHER;
    if (s_tuser) begin
      q_rec.act       = ACT_END;
      prev_class_next = CLS_START;
    end else if (is_digit) begin
      q_rec.act      = ACT_DIGIT;
      in_number_next = 1'b1;
    end else if (s_tdata == CH_OPEN) begin
      q_rec.act       = ACT_OPEN;
      q_rec.code      = CODE_OPEN;
      prev_class_next = CLS_OPEN;
    end else if (s_tdata == CH_CLOSE) begin
      q_rec.act = ACT_CLOSE;
    end else if (code != CODE_NONE) begin
      q_rec.act       = (code == CODE_MINUS && prev_class != CLS_OTHER) ? ACT_UNARY : ACT_BIN;
      prev_class_next = CLS_OPER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_number  <= 1'b0;
      prev_class <= CLS_START;
    end else if (q_push) begin
      in_number  <= in_number_next;
      prev_class <= prev_class_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/itp_queue.sv =====
// Short record queue between the front end and the stack engine.
`default_nettype none
module itp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire itp_pkg::rec_t push_rec,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output itp_pkg::rec_t      head
);
  import itp_pkg::*;

  rec_t             mem [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr;
  logic [QP_W-1:0]  rd_ptr;
  logic [QP_W:0]    fill;
  logic             do_pop;

  assign full       = (fill == (QP_W + 1)'(Q_DEPTH));
  assign head_valid = (fill != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/itp_back.sv =====
// Stack engine: runs queued records against the operator stack and emits results.
`default_nettype none
module itp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire itp_pkg::rec_t head,
  output logic               q_pop,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [7:0]         m_tdata,   // out_char
  output logic               m_tlast,   // last
  output logic               m_tuser    // overflow
);
  import itp_pkg::*;

  localparam logic [2:0] S_START  = 3'd0;
  localparam logic [2:0] S_SPACE  = 3'd1;
  localparam logic [2:0] S_DIGIT  = 3'd2;
  localparam logic [2:0] S_ENDPOP = 3'd3;
  localparam logic [2:0] S_POP    = 3'd4;
  localparam logic [2:0] S_POPSP  = 3'd5;
  localparam logic [2:0] S_ZERO   = 3'd6;
  localparam logic [2:0] S_ZSP    = 3'd7;

  logic [2:0]       stack [STACK_DEPTH];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [2:0]       state;
  logic [2:0]       state_next;
  logic             ovf;
  logic             ovf_next;
  rec_t             cur;
  rec_t             sel;
  logic [IDX_W-1:0] top_idx;
  logic [2:0]       top_code;
  logic             full_stk;
  logic             popc;
  logic             can_emit;
  logic             emit;
  logic [7:0]       emit_char;
  logic             emit_last;
  logic             push_en;
  logic [2:0]       push_code;

  assign can_emit = !m_tvalid || m_tready;
  assign sel      = (state == S_START) ? head : cur;
  assign top_idx  = IDX_W'(count - 1'b1);
  assign top_code = stack[top_idx];
  assign full_stk = (count == CNT_W'(STACK_DEPTH));

  always_comb begin
    popc = 1'b0;
    if (count != '0) begin
      if (sel.act == ACT_BIN) begin
        popc = code_prec(top_code) >= code_prec(sel.code);
      end else if (sel.act == ACT_CLOSE) begin
        popc = top_code != CODE_OPEN;
      end
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    q_pop      = 1'b0;
    emit       = 1'b0;
    emit_char  = CH_SPACE;
    emit_last  = 1'b0;
    push_en    = 1'b0;
    push_code  = CODE_OPEN;
    case (state)
      S_START: begin
        if (head_valid) begin
          q_pop = 1'b1;
          if (full_stk && (head.act == ACT_OPEN || head.act == ACT_UNARY ||
                           (head.act == ACT_BIN && !popc))) begin
            ovf_next = 1'b1;
          end
          if (head.space_first) begin
            state_next = S_SPACE;
          end else begin
            case (head.act)
              ACT_END:             state_next = S_ENDPOP;
              ACT_DIGIT:           state_next = S_DIGIT;
              ACT_CLOSE, ACT_BIN:  state_next = S_POP;
              ACT_UNARY:           state_next = S_ZERO;
              ACT_OPEN:            push_en    = 1'b1;
              default:             state_next = S_START;
            endcase
          end
        end
      end
      S_SPACE: begin
        if (can_emit) begin
          emit = 1'b1;
          case (cur.act)
            ACT_END: begin
              state_next = S_ENDPOP;
            end
            ACT_CLOSE, ACT_BIN: begin
              emit_last  = !popc;
              state_next = S_POP;
            end
            ACT_UNARY: begin
              state_next = S_ZERO;
            end
            ACT_OPEN: begin
              emit_last  = 1'b1;
              push_en    = 1'b1;
              state_next = S_START;
            end
            default: begin
              emit_last  = 1'b1;
              state_next = S_START;
            end
          endcase
        end
      end
      S_DIGIT: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_char  = cur.ch;
          emit_last  = 1'b1;
          state_next = S_START;
        end
      end
      S_ENDPOP: begin
        if (can_emit) begin
          emit = 1'b1;
          if (count != '0) begin
            emit_char  = code_char(top_code);
            count_next = count - 1'b1;
          end else begin
            emit_char  = CH_NUL;
            emit_last  = 1'b1;
            state_next = S_START;
          end
        end
      end
      S_POP: begin
        if (popc) begin
          if (can_emit) begin
            emit       = 1'b1;
            emit_char  = code_char(top_code);
            count_next = count - 1'b1;
            state_next = S_POPSP;
          end
        end else begin
          if (cur.act == ACT_BIN) begin
            push_en   = 1'b1;
            push_code = cur.code;
          end else if (count != '0) begin
            count_next = count - 1'b1;
          end
          state_next = S_START;
        end
      end
      S_POPSP: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_last  = !popc;
          state_next = S_POP;
        end
      end
      S_ZERO: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_char  = CH_ZERO;
          state_next = S_ZSP;
        end
      end
      S_ZSP: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          push_en    = 1'b1;
          push_code  = CODE_MINUS;
          state_next = S_START;
        end
      end
      default: begin
        state_next = S_START;
      end
    endcase
    if (push_en && !full_stk) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_en && !full_stk) begin
      stack[IDX_W'(count)] <= push_code;
    end
    if (state == S_START && head_valid) begin
      cur <= head;
    end
    if (emit) begin
      m_tdata <= emit_char;
      m_tlast <= emit_last;
      m_tuser <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_START;
      count    <= '0;
      ovf      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/itp_checker.sv =====
// Port-level checker for the infix to postfix converter and its bind.
`default_nettype none
module itp_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  logic ovf_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovf_seen <= 1'b0;
    end else if (m_tvalid && m_tready && m_tuser) begin
      ovf_seen <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                                 $stable(m_tuser)))
    else $error("output changed while stalled");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && ovf_seen) |-> m_tuser)
    else $error("overflow flag dropped after being reported");

  a_term_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata == 8'h00) |-> m_tlast)
    else $error("terminator not marked last");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/infix_to_postfix_converter_tb.sv =====
// Self-checking testbench for the infix to postfix converter with a scoreboard.
`default_nettype none
module infix_to_postfix_converter_tb;
  import itp_pkg::*;

  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS  = 100;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       overflow;
  } postfix_char_t;

  class postfix_scoreboard;
    logic [7:0]    op_stack [STACK_DEPTH];
    int unsigned   stack_fill;
    bit            in_number;
    logic [1:0]    prev_class;
    bit            overflow_seen;
    postfix_char_t postfix_queue [$];
    int            mismatch_count;

    function new();
      stack_fill     = 0;
      in_number      = 1'b0;
      prev_class     = CLS_START;
      overflow_seen  = 1'b0;
      mismatch_count = 0;
    endfunction

    function int prec_of(logic [7:0] c);
      case (c)
        CH_OPEN:                   return 0;
        CH_PLUS, CH_MINUS:         return 1;
        CH_STAR, CH_SLASH, CH_PCT: return 2;
        CH_CARET:                  return 3;
        default:                   return -1;
      endcase
    endfunction

    function void push_op(logic [7:0] c);
      if (stack_fill < STACK_DEPTH) begin
        op_stack[stack_fill] = c;
        stack_fill = stack_fill + 1;
      end else begin
        overflow_seen = 1'b1;
      end
    endfunction

    function void note_input(bit kind, logic [7:0] ch);
      logic [7:0] chars [$];
      postfix_char_t item;
      chars = {};
      if (kind) begin
        if (in_number) chars.push_back(CH_SPACE);
        while (stack_fill > 0) begin
          stack_fill = stack_fill - 1;
          chars.push_back(op_stack[stack_fill]);
        end
        chars.push_back(CH_NUL);
        in_number  = 1'b0;
        prev_class = CLS_START;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
        chars.push_back(ch);
        in_number  = 1'b1;
        prev_class = CLS_OTHER;
      end else begin
        if (in_number) chars.push_back(CH_SPACE);
        in_number = 1'b0;
        if (ch == CH_OPEN) begin
          push_op(CH_OPEN);
          prev_class = CLS_OPEN;
        end else if (ch == CH_CLOSE) begin
          while (stack_fill > 0 && op_stack[stack_fill - 1] != CH_OPEN) begin
            stack_fill = stack_fill - 1;
            chars.push_back(op_stack[stack_fill]);
            chars.push_back(CH_SPACE);
          end
          if (stack_fill > 0) stack_fill = stack_fill - 1;
          prev_class = CLS_OTHER;
        end else if (prec_of(ch) > 0) begin
          if (ch == CH_MINUS && prev_class != CLS_OTHER) begin
            chars.push_back(CH_ZERO);
            chars.push_back(CH_SPACE);
          end else begin
            while (stack_fill > 0 && prec_of(op_stack[stack_fill - 1]) >= prec_of(ch)) begin
              stack_fill = stack_fill - 1;
              chars.push_back(op_stack[stack_fill]);
              chars.push_back(CH_SPACE);
            end
          end
          push_op(ch);
          prev_class = CLS_OPER;
        end else begin
          prev_class = CLS_OTHER;
        end
      end
      foreach (chars[i]) begin
        item.out_char = chars[i];
        item.last     = (i == chars.size() - 1);
        item.overflow = overflow_seen;
        postfix_queue.push_back(item);
      end
    endfunction

    function void check_result(logic [7:0] out_char, logic last, logic overflow);
      postfix_char_t want;
      if (postfix_queue.size() == 0) begin
        $error("out_char: expected none, actual %02h", out_char);
        mismatch_count++;
        return;
      end
      want = postfix_queue.pop_front();
      if (out_char !== want.out_char) begin
        $error("out_char: expected %02h, actual %02h", want.out_char, out_char);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, actual %0b", want.last, last);
        mismatch_count++;
      end
      if (overflow !== want.overflow) begin
        $error("overflow: expected %0b, actual %0b", want.overflow, overflow);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return postfix_queue.size();
    endfunction
  endclass

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;  // ch
  logic       s_tuser  = 1'b0;   // kind
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // out_char
  logic       m_tlast;           // last
  logic       m_tuser;           // overflow
  logic       hold_off = 1'b0;

  int send_idle_pct = 19;
  int recv_idle_pct = 84;
  int phase_items;

  postfix_scoreboard sb = new();

  infix_to_postfix_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  task automatic send_item(bit kind, logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= ch;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(kind, ch);
  endtask

  task automatic send_text(string text);
    for (int i = 0; i < text.len(); i++) send_item(1'b0, text[i]);
  endtask

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_PCT;
      default: return CH_CARET;
    endcase
  endfunction

  // Bounded shape: at most 6 operands and 3 open brackets keep the stack below full.
  task automatic send_expression();
    logic [7:0] text [$];
    logic [7:0] digit;
    int operands;
    int opens;
    int open_budget;
    text        = {};
    operands    = $urandom_range(1, 6);
    opens       = 0;
    open_budget = 3;
    for (int k = 0; k < operands; k++) begin
      if (open_budget > 0 && $urandom_range(3) == 0) begin
        text.push_back(CH_OPEN);
        opens++;
        open_budget--;
      end
      if ($urandom_range(4) == 0) text.push_back(CH_MINUS);
      repeat ($urandom_range(1, 3)) begin
        digit = CH_ZERO + 8'($urandom_range(9));
        text.push_back(digit);
      end
      while (opens > 0 && $urandom_range(2) == 0) begin
        text.push_back(CH_CLOSE);
        opens--;
      end
      if (k < operands - 1) text.push_back(pick_operator());
      if ($urandom_range(9) == 0) text.push_back(CH_SPACE);
    end
    if ($urandom_range(4) != 0) begin
      while (opens > 0) begin
        text.push_back(CH_CLOSE);
        opens--;
      end
    end
    if ($urandom_range(99) < 15) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
    foreach (text[i]) send_item(1'b0, text[i]);
    send_item(1'b1, 8'($urandom_range(255)));
    phase_items += text.size() + 1;
  endtask

  task automatic run_phase(int send_pct, int recv_pct);
    send_idle_pct <= send_pct;
    recv_idle_pct <= recv_pct;
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) begin
      if ($urandom_range(99) < 80) begin
        send_expression();
      end else begin
        repeat ($urandom_range(1, 3)) begin
          send_item($urandom_range(3) == 0, 8'($urandom_range(255)));
          phase_items++;
        end
      end
    end
  endtask

  initial begin
    forever begin
      m_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
    end
  end

  initial begin
    int quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("(-9^2)%0/1*3+4-5");
    send_item(1'b1, 8'hFF);
    send_text("-x-7)");
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'h00);

    run_phase(19, 84);
    run_phase(84, 19);
    fork
      begin
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    run_phase(0, 0);

    // Fill the stack with unary minus, overflow it, then drain with a full close.
    repeat (STACK_DEPTH + 1) send_item(1'b0, CH_MINUS);
    send_item(1'b0, CH_NINE);
    send_item(1'b0, CH_CLOSE);
    send_item(1'b1, CH_NUL);
    s_tvalid <= 1'b0;

    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      if (sb.pending() > 0) $error("out_char: %0d results never arrived", sb.pending());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
